FILE: hw/rtl/nibble_frame_receiver_queue_defines.svh
// Assertion helpers for the RTL, used by nibble_frame_receiver_queue.
`ifndef NIBBLE_FRAME_RECEIVER_QUEUE_DEFINES_SVH
`define NIBBLE_FRAME_RECEIVER_QUEUE_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define NFRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked every cycle, disabled while reset is asserted.
`define NFRQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/nfrq_pkg.sv
package nfrq_pkg;

  localparam int unsigned QueueDepth = 8;
  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  // Fixed field widths
  localparam int unsigned ActW   = 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned StatW  = 3;
  localparam int unsigned NibW   = 4;
  localparam int unsigned PendW  = 4;
  localparam int unsigned MsgW   = 4 * NibW;
  localparam int unsigned PartW  = 3 * NibW;

  localparam logic [NibW-1:0] FirstMark = 4'hF;
  localparam logic [NibW-1:0] LastMark  = 4'hE;

  // Action codes
  localparam logic [ActW-1:0] ActByte  = 2'd0;
  localparam logic [ActW-1:0] ActRead  = 2'd1;
  localparam logic [ActW-1:0] ActClear = 2'd2;

  // Status codes
  localparam logic [StatW-1:0] StAccepted = 3'd0;
  localparam logic [StatW-1:0] StStored   = 3'd1;
  localparam logic [StatW-1:0] StBadFirst = 3'd2;
  localparam logic [StatW-1:0] StBadThird = 3'd3;
  localparam logic [StatW-1:0] StFull     = 3'd4;
  localparam logic [StatW-1:0] StRead     = 3'd5;
  localparam logic [StatW-1:0] StEmpty    = 3'd6;
  localparam logic [StatW-1:0] StCleared  = 3'd7;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic             store_req;
    logic [MsgW-1:0]  msg;
  } parse_res_t;

  typedef struct packed {
    logic store_en;
    logic pop_en;
    logic clear_en;
  } slot_ctrl_t;

  typedef struct packed {
    logic [IdxW-1:0] head;
    logic            head_pending;
    logic            free_found;
    logic [IdxW-1:0] free_idx;
    logic [CntW-1:0] count_nxt;
  } slot_info_t;

endpackage

FILE: hw/rtl/nfrq_if.sv
interface nfrq_in_if import nfrq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ActW-1:0]  action;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, action, rx_byte, input ready);
  modport sink (input valid, action, rx_byte, output ready);
endinterface

interface nfrq_out_if import nfrq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [StatW-1:0]  status;
  logic [NibW-1:0]   msg_type;
  logic [NibW-1:0]   value_one;
  logic [NibW-1:0]   value_two;
  logic [NibW-1:0]   value_three;
  logic [PendW-1:0]  pending_count;

  modport source (output valid, status, msg_type, value_one, value_two, value_three,
                  pending_count, input ready);
  modport sink (input valid, status, msg_type, value_one, value_two, value_three,
                pending_count, output ready);
endinterface

FILE: hw/rtl/nibble_frame_receiver_queue.sv
// Channel  Dir  Port   Payload
// -------  ---  -----  -----------------------------------------------------------
// in       in   in_i   action, rx_byte
// out      out  out_o  status, msg_type, value_one, value_two, value_three,
//                      pending_count
//
// Byte and clear items are answered directly; a read that pops a message first
// passes through StRdWait, since the message store is a synchronous RAM.
// The result sits in an output register; a new item is taken in the cycle the
// previous result leaves, so a stalled out channel stalls the input.
// Reset clears the parser, the pending marks and the head; messages are not.
`include "nibble_frame_receiver_queue_defines.svh"

module nibble_frame_receiver_queue import nfrq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  nfrq_in_if.sink    in_i,
  nfrq_out_if.source out_o
);

  typedef enum logic [1:0] {
    StIdle   = 2'b01,
    StRdWait = 2'b10
  } fsm_e;

  fsm_e state_q, state_d;

  parse_res_t parse;
  slot_ctrl_t ctrl;
  slot_info_t info;

  logic            in_acc, byte_en, pop_en;
  logic            ram_we;
  logic [MsgW-1:0] ram_rdata;

  logic             out_valid_q, out_valid_d;
  logic [StatW-1:0] status_q, status_d;
  logic [MsgW-1:0]  msg_q, msg_d;
  logic [PendW-1:0] count_q, count_d;

  assign in_i.ready = (state_q == StIdle) && (!out_valid_q || out_o.ready);
  assign in_acc     = in_i.valid && in_i.ready;
  assign byte_en    = in_acc && (in_i.action == ActByte);
  assign pop_en     = in_acc && (in_i.action == ActRead) && info.head_pending;

  assign ctrl.store_en = byte_en && parse.store_req;
  assign ctrl.pop_en   = pop_en;
  assign ctrl.clear_en = in_acc && (in_i.action == ActClear);

  assign ram_we = ctrl.store_en && info.free_found;

  nfrq_parser u_parser (
    .clk_i,
    .rst_ni,
    .byte_en_i (byte_en),
    .rx_byte_i (in_i.rx_byte),
    .res_o     (parse)
  );

  nfrq_slot_ctrl u_slots (
    .clk_i,
    .rst_ni,
    .ctrl_i (ctrl),
    .info_o (info)
  );

  nfrq_msg_ram #(
    .Width (MsgW),
    .Depth (QueueDepth),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (info.free_idx),
    .wdata_i (parse.msg),
    .re_i    (pop_en),
    .raddr_i (info.head),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_o.ready;
    status_d    = status_q;
    msg_d       = msg_q;
    count_d     = count_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          count_d = PendW'(info.count_nxt);
          msg_d   = '0;
          case (in_i.action)
            ActByte: begin
              status_d = (parse.store_req && !info.free_found) ? StFull : parse.status;
            end
            ActRead:  status_d = info.head_pending ? StRead : StEmpty;
            ActClear: status_d = StCleared;
            default:  status_d = StAccepted;
          endcase
          if (pop_en) begin
            state_d = StRdWait;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      StRdWait: begin
        msg_d       = ram_rdata;
        out_valid_d = 1'b1;
        state_d     = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    msg_q    <= msg_d;
    count_q  <= count_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = status_q;
  assign out_o.msg_type      = msg_q[15:12];
  assign out_o.value_one     = msg_q[11:8];
  assign out_o.value_two     = msg_q[7:4];
  assign out_o.value_three   = msg_q[3:0];
  assign out_o.pending_count = count_q;

  `NFRQ_ASSERT_IMP(a_rdwait_out_free, state_q == StRdWait, !out_valid_q, "busy output")
  `NFRQ_ASSERT(a_pop_wait, pop_en |=> (state_q == StRdWait && status_q == StRead), "pop no wait")
  `NFRQ_ASSERT(a_rd_done, (state_q == StRdWait) |=> (out_valid_q && state_q == StIdle), "read lost")
  `NFRQ_ASSERT_IMP(a_count_bound, out_valid_q, count_q <= PendW'(QueueDepth), "count over depth")

endmodule

FILE: hw/rtl/nfrq_msg_ram.sv
module nfrq_msg_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: hw/rtl/nfrq_parser.sv
module nfrq_parser import nfrq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             byte_en_i,
  input  logic [ByteW-1:0] rx_byte_i,
  output parse_res_t       res_o
);

  typedef enum logic [2:0] {
    PhHunt   = 3'b001,
    PhSecond = 3'b010,
    PhThird  = 3'b100
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [PartW-1:0] partial_q, partial_d;

  always_comb begin
    phase_d       = phase_q;
    partial_d     = partial_q;
    res_o.status    = StAccepted;
    res_o.store_req = 1'b0;
    res_o.msg       = {partial_q, rx_byte_i[7:4]};
    case (phase_q)
      PhHunt: begin
        if (rx_byte_i[7:4] != FirstMark) begin
          res_o.status = StBadFirst;
        end else begin
          partial_d = {rx_byte_i[3:0], 8'h00};
          phase_d   = PhSecond;
        end
      end
      PhSecond: begin
        partial_d = {partial_q[11:8], rx_byte_i};
        phase_d   = PhThird;
      end
      PhThird: begin
        // third byte closes the frame either way
        phase_d = PhHunt;
        if (rx_byte_i[3:0] != LastMark) begin
          res_o.status = StBadThird;
        end else begin
          res_o.status    = StStored;
          res_o.store_req = 1'b1;
        end
      end
      default: phase_d = PhHunt;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      partial_q <= '0;
    end else if (byte_en_i) begin
      phase_q   <= phase_d;
      partial_q <= partial_d;
    end
  end

endmodule

FILE: hw/rtl/nfrq_slot_ctrl.sv
module nfrq_slot_ctrl import nfrq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  slot_ctrl_t ctrl_i,
  output slot_info_t info_o
);

  logic [QueueDepth-1:0] pending_q, pending_d;
  logic [IdxW-1:0]       head_q, head_d;
  logic [IdxW:0]         head_inc;
  logic                  free_found;
  logic [IdxW-1:0]       free_idx;

  // circular first-free search starting at the head
  always_comb begin
    logic [IdxW:0] sum;
    free_found = 1'b0;
    free_idx   = head_q;
    for (int i = QueueDepth - 1; i >= 0; i--) begin
      sum = {1'b0, head_q} + (IdxW + 1)'(i);
      if (sum >= (IdxW + 1)'(QueueDepth)) begin
        sum = sum - (IdxW + 1)'(QueueDepth);
      end
      if (!pending_q[sum[IdxW-1:0]]) begin
        free_found = 1'b1;
        free_idx   = sum[IdxW-1:0];
      end
    end
  end

  always_comb begin
    head_inc = {1'b0, head_q} + (IdxW + 1)'(1);
    if (head_inc >= (IdxW + 1)'(QueueDepth)) begin
      head_inc = '0;
    end
    pending_d = pending_q;
    head_d    = head_q;
    if (ctrl_i.clear_en) begin
      pending_d = '0;
    end else if (ctrl_i.pop_en) begin
      pending_d[head_q] = 1'b0;
      head_d            = head_inc[IdxW-1:0];
    end else if (ctrl_i.store_en && free_found) begin
      pending_d[free_idx] = 1'b1;
    end
  end

  assign info_o.head         = head_q;
  assign info_o.head_pending = pending_q[head_q];
  assign info_o.free_found   = free_found;
  assign info_o.free_idx     = free_idx;
  assign info_o.count_nxt    = CntW'($countones(pending_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      head_q    <= '0;
    end else begin
      pending_q <= pending_d;
      head_q    <= head_d;
    end
  end

endmodule
